/* rtl/cji_pkg.sv */
package cji_pkg;

  localparam int PW    = 32;            // position / velocity width
  localparam int TW    = 24;            // time width
  localparam int FW    = 26;            // multiplier factor width
  localparam int NCH   = 4;             // product chains
  localparam int NSTEP = 4;             // factors per chain
  localparam int LW    = 32;            // multiplier lane width
  localparam int AW    = 136;           // chain accumulator width
  localparam int NL    = (AW + LW - 1) / LW;
  localparam int PPW   = LW + FW;       // partial product width
  localparam int NW    = 131;           // signed numerator width
  localparam int XW    = 132;           // dividend width
  localparam int QW    = 33;            // quotient bits kept
  localparam int D3W   = 72;            // D^3 width
  localparam int DEN_SHIFT = 20;

  localparam int CH_TARGET    = 0;      // |p1w - p0| * u * u * (3D - 2u) * 2^20
  localparam int CH_START_VEL = 1;      // |v0| * u * (D - u)^2 * D
  localparam int CH_END_VEL   = 2;      // |v1| * u^2 * (D - u) * D
  localparam int CH_CUBE      = 3;      // D^3

  localparam logic signed [PW-1:0] WRAP_LIMIT     = 32'sd100143639;
  localparam logic signed [PW-1:0] NEG_WRAP_LIMIT = -32'sd100143639;
  localparam logic signed [PW-1:0] WRAP_STEP      = 32'sd105414357;
  localparam logic signed [PW-1:0] POS_MAX        = 32'sh7FFFFFFF;
  localparam logic signed [PW-1:0] POS_MIN        = 32'sh80000000;
  localparam logic [TW-1:0]        MAX_DURATION_RESET = 24'd3670016;
  localparam logic [FW-1:0]        FAC_ONE  = 26'd1;
  localparam logic [FW-1:0]        FAC_FRAC = 26'h0100000;

  typedef struct packed {
    logic signed [PW-1:0] start_position;
    logic signed [PW-1:0] start_velocity;
    logic signed [PW-1:0] end_position;
    logic signed [PW-1:0] end_velocity;
    logic [TW-1:0]        elapsed_time;
    logic [TW-1:0]        move_duration;
  } in_item_t;

  typedef struct packed {
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1w;
    logic                 active;
    logic [NCH-2:0]       neg_term;
  } side_t;

  typedef struct packed {
    side_t                                side;
    logic [NCH-1:0][AW-1:0]               acc;
    logic [NCH-1:0][NSTEP-1:0][FW-1:0]    fac;
  } mst_t;

  typedef struct packed {
    side_t                                side;
    logic [NCH-1:0][NL-1:0][PPW-1:0]      pp;
    logic [NCH-1:0][NSTEP-1:0][FW-1:0]    fac;
  } pst_t;

  typedef struct packed {
    side_t                side;
    logic signed [NW-1:0] n;
    logic [D3W-1:0]       d3;
  } sum_t;

  typedef struct packed {
    side_t          side;
    logic           neg;
    logic           big;
    logic [XW-1:0]  rem;
    logic [D3W-1:0] d3;
    logic [QW-1:0]  quo;
  } dst_t;

endpackage

/* rtl/cji_joint_if.sv */
interface cji_joint_if;
  logic                          valid;
  logic                          ready;
  logic signed [cji_pkg::PW-1:0] start_position;
  logic signed [cji_pkg::PW-1:0] start_velocity;
  logic signed [cji_pkg::PW-1:0] end_position;
  logic signed [cji_pkg::PW-1:0] end_velocity;
  logic [cji_pkg::TW-1:0]        elapsed_time;
  logic [cji_pkg::TW-1:0]        move_duration;

  modport source (output valid, start_position, start_velocity, end_position, end_velocity,
                  elapsed_time, move_duration, input ready);
  modport sink (input valid, start_position, start_velocity, end_position, end_velocity,
                elapsed_time, move_duration, output ready);
endinterface

/* rtl/cji_cmd_if.sv */
interface cji_cmd_if;
  logic                          valid;
  logic                          ready;
  logic signed [cji_pkg::PW-1:0] position;
  logic                          saturated;

  modport source (output valid, position, saturated, input ready);
  modport sink (input valid, position, saturated, output ready);
endinterface

/* rtl/cji_front.sv */
module cji_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [cji_pkg::TW-1:0] max_duration,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cji_pkg::in_item_t      in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cji_pkg::mst_t          out_item
);
  import cji_pkg::*;

  logic signed [PW-1:0] p1w;
  logic [TW-1:0]        dur;
  logic [TW-1:0]        span;
  logic [FW-1:0]        blend;
  logic signed [PW:0]   diff;
  logic [PW:0]          diff_neg;
  logic [PW-1:0]        dmag;
  logic [PW-1:0]        v0mag;
  logic [PW-1:0]        v1mag;
  logic [FW-1:0]        fu;
  logic [FW-1:0]        fd;
  logic [FW-1:0]        fe;
  mst_t                 item_next;

  always_comb begin
    // one-turn wrap of the target
    if (in_item.end_position > WRAP_LIMIT) begin
      p1w = in_item.end_position - WRAP_STEP;
    end else if (in_item.end_position < NEG_WRAP_LIMIT) begin
      p1w = in_item.end_position + WRAP_STEP;
    end else begin
      p1w = in_item.end_position;
    end
    dur   = (in_item.move_duration > max_duration) ? max_duration : in_item.move_duration;
    span  = dur - in_item.elapsed_time;
    blend = {2'b00, dur} + {1'b0, dur, 1'b0} - {1'b0, in_item.elapsed_time, 1'b0};
    diff  = {p1w[PW-1], p1w} - {in_item.start_position[PW-1], in_item.start_position};
    diff_neg = -diff;
    dmag  = diff[PW] ? diff_neg[PW-1:0] : diff[PW-1:0];
    v0mag = in_item.start_velocity[PW-1] ? PW'(-in_item.start_velocity)
                                         : PW'(in_item.start_velocity);
    v1mag = in_item.end_velocity[PW-1] ? PW'(-in_item.end_velocity)
                                       : PW'(in_item.end_velocity);
    fu = FW'(in_item.elapsed_time);
    fd = FW'(dur);
    fe = FW'(span);

    item_next.side.p0     = in_item.start_position;
    item_next.side.p1w    = p1w;
    item_next.side.active = in_item.elapsed_time < dur;
    item_next.side.neg_term[CH_TARGET]    = diff[PW];
    item_next.side.neg_term[CH_START_VEL] = in_item.start_velocity[PW-1];
    item_next.side.neg_term[CH_END_VEL]   = !in_item.end_velocity[PW-1] &&
                                            (in_item.end_velocity != '0);

    item_next.acc[CH_TARGET]    = AW'(dmag);
    item_next.acc[CH_START_VEL] = AW'(v0mag);
    item_next.acc[CH_END_VEL]   = AW'(v1mag);
    item_next.acc[CH_CUBE]      = AW'(dur);

    item_next.fac[CH_TARGET][0] = fu;
    item_next.fac[CH_TARGET][1] = fu;
    item_next.fac[CH_TARGET][2] = blend;
    item_next.fac[CH_TARGET][3] = FAC_FRAC;
    item_next.fac[CH_START_VEL][0] = fu;
    item_next.fac[CH_START_VEL][1] = fe;
    item_next.fac[CH_START_VEL][2] = fe;
    item_next.fac[CH_START_VEL][3] = fd;
    item_next.fac[CH_END_VEL][0] = fu;
    item_next.fac[CH_END_VEL][1] = fu;
    item_next.fac[CH_END_VEL][2] = fe;
    item_next.fac[CH_END_VEL][3] = fd;
    item_next.fac[CH_CUBE][0] = fd;
    item_next.fac[CH_CUBE][1] = fd;
    item_next.fac[CH_CUBE][2] = FAC_ONE;
    item_next.fac[CH_CUBE][3] = FAC_ONE;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end
endmodule

/* rtl/cji_mul.sv */
module cji_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cji_pkg::mst_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output cji_pkg::sum_t out_item
);
  import cji_pkg::*;

  localparam int NS = 2 * NSTEP + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [NS-1:0] vsrc;
  pst_t          pst [NSTEP];
  mst_t          mst [NSTEP];
  mst_t          msrc [NSTEP];
  sum_t          cmb_next;

  function automatic logic [LW-1:0] lane_of(input logic [AW-1:0] a, input int l);
    logic [NL*LW-1:0] padded;
    padded = (NL*LW)'(a);
    return padded[l*LW +: LW];
  endfunction

  // a stage loads when empty or when the next one moves
  assign en[NS-1] = !vld[NS-1] || out_ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign vsrc      = {vld[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) vld[s] <= vsrc[s];
      end
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [NCH-1:0][NL-1:0][PPW-1:0] pp_next;
    logic [NCH-1:0][AW-1:0]          acc_next;

    if (k == 0) begin : g_first
      assign msrc[k] = in_item;
    end else begin : g_rest
      assign msrc[k] = mst[k-1];
    end

    // lane partial products, 32 x 26 each
    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        for (int l = 0; l < NL; l++) begin
          pp_next[c][l] = PPW'(lane_of(msrc[k].acc[c], l)) * PPW'(msrc[k].fac[c][k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2*k]) begin
        pst[k].side <= msrc[k].side;
        pst[k].fac  <= msrc[k].fac;
        pst[k].pp   <= pp_next;
      end
    end

    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        acc_next[c] = '0;
        for (int l = 0; l < NL; l++) begin
          acc_next[c] = acc_next[c] + (AW'(pst[k].pp[c][l]) << (l * LW));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2*k+1]) begin
        mst[k].side <= pst[k].side;
        mst[k].fac  <= pst[k].fac;
        mst[k].acc  <= acc_next;
      end
    end
  end

  // signed sum of the three Hermite terms
  always_comb begin
    cmb_next.side = mst[NSTEP-1].side;
    cmb_next.d3   = mst[NSTEP-1].acc[CH_CUBE][D3W-1:0];
    cmb_next.n    = '0;
    for (int c = 0; c < NCH - 1; c++) begin
      if (mst[NSTEP-1].side.neg_term[c]) begin
        cmb_next.n = cmb_next.n - $signed(NW'(mst[NSTEP-1].acc[c]));
      end else begin
        cmb_next.n = cmb_next.n + $signed(NW'(mst[NSTEP-1].acc[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_item <= cmb_next;
    end
  end
endmodule

/* rtl/cji_div.sv */
module cji_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cji_pkg::sum_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output cji_pkg::dst_t out_item
);
  import cji_pkg::*;

  localparam int NS = QW + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [NS-1:0] vsrc;
  dst_t          st [NS];
  dst_t          norm_next;
  logic [NW-1:0] mag;
  logic [NW-1:0] n_neg;

  assign en[NS-1] = !vld[NS-1] || out_ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign vsrc      = {vld[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];
  assign out_item  = st[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) vld[s] <= vsrc[s];
      end
    end
  end

  // dividend 2|N| + D^3*2^20, divisor D^3*2^21; big when quotient >= 2^QW
  always_comb begin
    n_neg = -in_item.n;
    mag   = in_item.n[NW-1] ? n_neg : in_item.n;
    norm_next.side = in_item.side;
    norm_next.neg  = in_item.n[NW-1];
    norm_next.d3   = in_item.d3;
    norm_next.rem  = {mag, 1'b0} + (XW'(in_item.d3) << DEN_SHIFT);
    norm_next.big  = norm_next.rem >= (XW'(in_item.d3) << (DEN_SHIFT + 1 + QW));
    norm_next.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= norm_next;
    end
  end

  // one restoring step per stage, quotient MSB first
  for (genvar j = 1; j < NS; j++) begin : g_bit
    dst_t        nxt;
    logic [XW:0] dif;

    always_comb begin
      nxt = st[j-1];
      dif = {1'b0, st[j-1].rem} - {1'b0, XW'(st[j-1].d3) << (DEN_SHIFT + 1 + QW - j)};
      if (!dif[XW]) begin
        nxt.rem       = dif[XW-1:0];
        nxt.quo[QW-j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= nxt;
      end
    end
  end
endmodule

/* rtl/cubic_joint_interpolator.sv */
// Channel  Role    Handshake      Payload
// joint    sink    valid/ready    start/end position and velocity, elapsed_time, move_duration
// cmd      source  valid/ready    position, saturated
// cfg      write   cfg_we         cfg_wdata -> max_duration (24 bits, Q4.20 s)
//
// Takes one item per clock unless cmd stalls and the pipe is full; stages in order: front,
// multiplier chains, term sum, divide setup, restoring divider (one quotient bit per stage), output.
// The 33-stage divider by D^3*2^21 sets the depth.
// rst is synchronous: clears all stage valids and sets max_duration to 3.5 s.
// Each stage loads when empty or when its successor moves, so bubbles close up and
// the input keeps flowing while cmd is stalled until the pipe is full.
module cubic_joint_interpolator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [cji_pkg::TW-1:0] cfg_wdata,
  cji_joint_if.sink              joint,
  cji_cmd_if.source              cmd
);
  import cji_pkg::*;

  logic [TW-1:0] max_duration;

  // config register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration <= MAX_DURATION_RESET;
    end else if (cfg_we) begin
      max_duration <= cfg_wdata;
    end
  end

  in_item_t joint_item;
  assign joint_item.start_position = joint.start_position;
  assign joint_item.start_velocity = joint.start_velocity;
  assign joint_item.end_position   = joint.end_position;
  assign joint_item.end_velocity   = joint.end_velocity;
  assign joint_item.elapsed_time   = joint.elapsed_time;
  assign joint_item.move_duration  = joint.move_duration;

  logic front_valid, front_ready;
  mst_t front_item;
  logic mul_valid, mul_ready;
  sum_t mul_item;
  logic div_valid, div_ready;
  dst_t dq;

  // wrap, clamp, factor selection
  cji_front u_front (
    .clk          (clk),
    .rst          (rst),
    .max_duration (max_duration),
    .in_valid     (joint.valid),
    .in_ready     (joint.ready),
    .in_item      (joint_item),
    .out_valid    (front_valid),
    .out_ready    (front_ready),
    .out_item     (front_item)
  );

  // four product chains, then signed numerator N
  cji_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_item  (mul_item)
  );

  // rounded |N| / (D^3 * 2^20)
  cji_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_item   (mul_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (dq)
  );

  // final add, saturation, end-of-move select
  logic [PW+2:0]        sum;
  logic                 fits;
  logic signed [PW-1:0] position_next;
  logic                 saturated_next;

  always_comb begin
    if (dq.neg) begin
      sum = {{3{dq.side.p0[PW-1]}}, dq.side.p0} - {2'b00, dq.quo};
    end else begin
      sum = {{3{dq.side.p0[PW-1]}}, dq.side.p0} + {2'b00, dq.quo};
    end
    fits = (sum[PW+2:PW-1] == '0) || (sum[PW+2:PW-1] == '1);
    if (!dq.side.active) begin
      position_next  = dq.side.p1w;
      saturated_next = 1'b0;
    end else if (dq.big) begin
      position_next  = dq.neg ? POS_MIN : POS_MAX;
      saturated_next = 1'b1;
    end else if (!fits) begin
      position_next  = sum[PW+2] ? POS_MIN : POS_MAX;
      saturated_next = 1'b1;
    end else begin
      position_next  = $signed(sum[PW-1:0]);
      saturated_next = 1'b0;
    end
  end

  // output register
  assign div_ready = !cmd.valid || cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (div_ready) begin
      cmd.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      cmd.position  <= position_next;
      cmd.saturated <= saturated_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd.valid)
    else $error("output valid after reset");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst) !cmd.valid |-> joint.ready)
    else $error("input stalled with empty output register");

  a_sat_rails: assert property (@(posedge clk) disable iff (rst)
      cmd.valid && cmd.saturated |-> (cmd.position == POS_MAX) || (cmd.position == POS_MIN))
    else $error("saturated result off the rails");

  a_big_sat: assert property (@(posedge clk) disable iff (rst)
      div_valid && div_ready && dq.side.active && dq.big |=> cmd.valid && cmd.saturated)
    else $error("oversized quotient not saturated");

endmodule

/* test/cubic_joint_interpolator_tb.sv */
`timescale 1ns / 1ps

module cubic_joint_interpolator_tb;
  import cji_pkg::*;

  typedef struct {
    logic signed [31:0] position;
    logic               saturated;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TW-1:0] cfg_wdata = '0;

  cji_joint_if joint ();
  cji_cmd_if   cmd ();

  cubic_joint_interpolator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .joint     (joint.sink),
    .cmd       (cmd.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the duration clamp register
  logic [TW-1:0] clamp_dur = MAX_DURATION_RESET;

  in_item_t  joint_queue[$];     // items waiting to be offered
  cmd_item_t cmd_expected[$];    // predicted commands, oldest first

  int  send_idle_pct = 0;        // sender idle chance, percent
  int  recv_stall_pct = 0;       // receiver stall chance, percent
  int  hold_cycles = 0;          // forced receiver hold-off, counted by the monitor
  int  errors = 0;
  int  sent = 0;
  int  received = 0;
  longint cycles = 0;

  function automatic void add_move(in_item_t it);
    joint_queue.insert(joint_queue.size(), it);
  endfunction

  function automatic in_item_t take_move();
    in_item_t it;
    it = joint_queue[0];
    joint_queue.delete(0);
    return it;
  endfunction

  function automatic void add_expected(cmd_item_t c);
    cmd_expected.insert(cmd_expected.size(), c);
  endfunction

  function automatic cmd_item_t take_expected();
    cmd_item_t c;
    c = cmd_expected[0];
    cmd_expected.delete(0);
    return c;
  endfunction

  // Hermite position: exact rational sum, round half away from zero, then saturate.
  function automatic cmd_item_t hermite_position(in_item_t it, logic [TW-1:0] dmax);
    cmd_item_t r;
    logic signed [63:0] p0, v0, p1, v1, res;
    logic signed [199:0] num, uu, dd, den, mag, q;
    logic [TW-1:0] d;
    p0 = 64'(it.start_position);
    v0 = 64'(it.start_velocity);
    p1 = 64'(it.end_position);
    v1 = 64'(it.end_velocity);
    if (p1 > WRAP_LIMIT) p1 = p1 - WRAP_STEP;
    if (p1 < NEG_WRAP_LIMIT) p1 = p1 + WRAP_STEP;
    d = (it.move_duration > dmax) ? dmax : it.move_duration;
    r.saturated = 1'b0;
    if (it.elapsed_time < d) begin
      uu = 200'(it.elapsed_time);
      dd = 200'(d);
      num = (p1 - p0) * uu * uu * (3 * dd - 2 * uu) * (200'sd1 <<< 20)
          + v0 * dd * uu * (dd - uu) * (dd - uu)
          - v1 * dd * uu * uu * (dd - uu);
      den = dd * dd * dd * (200'sd1 <<< 20);
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      if (q + p0 > 64'sh7FFFFFFF) begin
        res = 64'sh7FFFFFFF;
        r.saturated = 1'b1;
      end else if (q + p0 < -64'sh80000000) begin
        res = -64'sh80000000;
        r.saturated = 1'b1;
      end else begin
        res = 64'(q + p0);
      end
    end else begin
      res = p1;
    end
    r.position = res[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
      2: return $urandom_range(0, 1) ? 32'd100143639 + $urandom_range(0, 2)
                                     : -32'sd100143639 - $urandom_range(0, 2);
      3: return $urandom_range(0, 1) ? POS_MAX - $urandom_range(0, 3)
                                     : POS_MIN + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  function automatic in_item_t rand_move();
    in_item_t it;
    it.start_position = rand_pos();
    it.start_velocity = $urandom_range(0, 3) == 0 ? $urandom : rand_pos();
    it.end_position   = rand_pos();
    it.end_velocity   = $urandom_range(0, 3) == 0 ? $urandom : rand_pos();
    case ($urandom_range(0, 3))
      0: it.move_duration = TW'($urandom);
      1: it.move_duration = TW'($urandom_range(0, 8));
      default: it.move_duration = TW'($urandom_range(1, 4000000));
    endcase
    case ($urandom_range(0, 5))
      0: it.elapsed_time = TW'($urandom);
      1: it.elapsed_time = it.move_duration;
      2: it.elapsed_time = (it.move_duration > '0) ? it.move_duration - TW'(1) : '0;
      default: it.elapsed_time = TW'($urandom_range(0, it.move_duration));
    endcase
    return it;
  endfunction

  function automatic in_item_t make_move(logic [31:0] p0, logic [31:0] v0, logic [31:0] p1,
                                         logic [31:0] v1, logic [TW-1:0] u, logic [TW-1:0] d);
    in_item_t it;
    it.start_position = p0;
    it.start_velocity = v0;
    it.end_position = p1;
    it.end_velocity = v1;
    it.elapsed_time = u;
    it.move_duration = d;
    return it;
  endfunction

  // Driver: valid stays high until the item is taken; new item loaded in the same edge.
  always @(posedge clk) begin
    if (rst) begin
      joint.valid <= 1'b0;
    end else begin
      if (!joint.valid || joint.ready) begin
        if (joint.valid) sent <= sent + 1;
        if (joint_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item_t it;
          it = take_move();
          joint.start_position <= it.start_position;
          joint.start_velocity <= it.start_velocity;
          joint.end_position   <= it.end_position;
          joint.end_velocity   <= it.end_velocity;
          joint.elapsed_time   <= it.elapsed_time;
          joint.move_duration  <= it.move_duration;
          joint.valid <= 1'b1;
          // prediction made at offer time; config never changes while items are queued
          add_expected(hermite_position(it, clamp_dur));
        end else begin
          joint.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted commands and drives ready with random stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      cmd.ready <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        received <= received + 1;
        if (cmd_expected.size() == 0) begin
          $error("unexpected command: position %0d", cmd.position);
          errors = errors + 1;
        end else begin
          cmd_item_t e;
          e = take_expected();
          if (cmd.position !== e.position) begin
            $error("position: expected %0d, got %0d", e.position, cmd.position);
            errors = errors + 1;
          end
          if (cmd.saturated !== e.saturated) begin
            $error("saturated: expected %0d, got %0d", e.saturated, cmd.saturated);
            errors = errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        cmd.ready <= 1'b0;
      end else begin
        cmd.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
    if (cycles > 64'd1000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    joint.valid = 1'b0;
    joint.start_position = '0;
    joint.start_velocity = '0;
    joint.end_position = '0;
    joint.end_velocity = '0;
    joint.elapsed_time = '0;
    joint.move_duration = '0;
    cmd.ready = 1'b0;
  end

  task automatic drain();
    // everything offered and answered, then a further idle wait to be sure
    while (joint_queue.size() != 0 || joint.valid || cmd_expected.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_clamp(logic [TW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    clamp_dur = value;
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) add_move(rand_move());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: default clamp
    add_move(make_move(0, 0, 32'd16777216, 0, 24'd524288, 24'd1048576));
    add_move(make_move(0, 0, 32'd16777216, 0, 0, 24'd1048576));
    add_move(make_move(0, 0, 32'd16777216, 0, 24'd1048576, 24'd1048576));
    add_move(make_move(0, 0, 32'd16777216, 0, 24'hFFFFFF, 24'd1048576));
    // zero duration
    add_move(make_move(5, 7, 32'd123, 9, 0, 0));
    // wrap thresholds, both sides, and at the limit exactly
    add_move(make_move(0, 0, 32'd100143640, 0, 1, 0));
    add_move(make_move(0, 0, 32'd100143639, 0, 1, 0));
    add_move(make_move(0, 0, -32'sd100143640, 0, 1, 0));
    add_move(make_move(0, 0, -32'sd100143639, 0, 1, 0));
    add_move(make_move(0, 0, POS_MAX, 0, 24'd3, 24'd8));
    // saturation both ways, extreme velocities
    add_move(make_move(POS_MAX, POS_MAX, POS_MAX, POS_MIN, 24'd100, 24'hFFFFFF));
    add_move(make_move(POS_MIN, POS_MIN, POS_MIN, POS_MAX, 24'd100, 24'hFFFFFF));
    add_move(make_move(POS_MAX, POS_MAX, POS_MIN, POS_MAX, 24'd2, 24'd3));
    add_move(make_move(POS_MIN, POS_MIN, POS_MAX, POS_MIN, 24'd1, 24'd3));
    // duration above the clamp
    add_move(make_move(1000, -1000, 32'd50000000, 32'd777, 24'd3670015, 24'hFFFFFF));
    add_move(make_move(1000, -1000, 32'd50000000, 32'd777, 24'd3670016, 24'hFFFFFF));
    add_move(make_move(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       24'h7FFFFF, 24'hFFFFFF));
    drain();

    random_phase(250, 0, 0);
    random_phase(200, 67, 0);

    // clamp to max, then receiver hold-off so the pipe fills and backs up the input
    write_clamp(24'hFFFFFF);
    hold_cycles = 300;
    random_phase(200, 0, 67);

    // clamp zero: every item goes straight to the target
    write_clamp(24'd0);
    random_phase(100, 6, 6);

    // tiny clamp: very short moves
    write_clamp(24'd1);
    random_phase(100, 0, 0);
    write_clamp(24'd5);
    random_phase(100, 67, 67);

    write_clamp(MAX_DURATION_RESET);
    random_phase(300, 6, 6);

    $display("Covered %0d joint items and %0d commands over five clamp values,", sent, received);
    $display("with directed wrap, saturation and end-of-move items and random stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cji_pkg.sv
rtl/cji_joint_if.sv
rtl/cji_cmd_if.sv
rtl/cji_front.sv
rtl/cji_mul.sv
rtl/cji_div.sv
rtl/cubic_joint_interpolator.sv
test/cubic_joint_interpolator_tb.sv
